// ----- hw/rtl/lsal_pkg.sv -----
// ----------------------------------------------------------------------------
// lsal_pkg
// Shared types, codes and the per-setting lux scale table.
// ----------------------------------------------------------------------------
package lsal_pkg;

  localparam int CNT_W   = 16;
  localparam int RB_W    = 8;
  localparam int LUX_W   = 20;
  localparam int CFG_W   = 17;
  localparam int CFGI_W  = 2;
  localparam int T_W     = 28;
  localparam int MAG_W   = 27;
  localparam int SCALE_W = 27;
  localparam int SLO_W   = 14;
  localparam int PROD_W  = MAG_W + SLO_W;
  localparam int ACC_W   = 54;
  localparam int QSH     = 34;

  // phase codes
  localparam logic [1:0] PH_READ  = 2'd0;
  localparam logic [1:0] PH_CALC  = 2'd1;
  localparam logic [1:0] PH_READY = 2'd2;
  localparam logic [1:0] PH_IDLE  = 2'd3;

  // power commands
  localparam logic [1:0] PWR_NONE    = 2'd0;
  localparam logic [1:0] PWR_SENSE   = 2'd1;
  localparam logic [1:0] PWR_NOSENSE = 2'd2;

  // gain / timing codes
  localparam logic [1:0] GAIN_LOW  = 2'd0;
  localparam logic [1:0] GAIN_MED  = 2'd1;
  localparam logic [1:0] GAIN_HIGH = 2'd2;
  localparam logic [2:0] TIM_SHORT = 3'd0;
  localparam logic [2:0] TIM_MID   = 3'd2;
  localparam logic [2:0] TIM_LONG  = 3'd4;

  // configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_ACTIVE     = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_IDLE_TICKS = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_BRIGHT     = 2'd2;
  localparam logic [CFGI_W-1:0] CFG_DIM_SUM    = 2'd3;

  localparam logic signed [LUX_W-1:0] LUX_INVALID = -20'sd1;

  // 408 * 2^24
  localparam longint unsigned LuxNum = 64'd6845104128;

  // Q24 scale, index {gain, timing}; round(LuxNum / ((t+1)*100*again))
  localparam logic [SCALE_W-1:0] SCALE_TAB [32] = '{
    27'((LuxNum + (1*100*1)/2) / (1*100*1)),
    27'((LuxNum + (2*100*1)/2) / (2*100*1)),
    27'((LuxNum + (3*100*1)/2) / (3*100*1)),
    27'((LuxNum + (4*100*1)/2) / (4*100*1)),
    27'((LuxNum + (5*100*1)/2) / (5*100*1)),
    27'((LuxNum + (6*100*1)/2) / (6*100*1)),
    27'((LuxNum + (7*100*1)/2) / (7*100*1)),
    27'((LuxNum + (8*100*1)/2) / (8*100*1)),
    27'((LuxNum + (1*100*25)/2) / (1*100*25)),
    27'((LuxNum + (2*100*25)/2) / (2*100*25)),
    27'((LuxNum + (3*100*25)/2) / (3*100*25)),
    27'((LuxNum + (4*100*25)/2) / (4*100*25)),
    27'((LuxNum + (5*100*25)/2) / (5*100*25)),
    27'((LuxNum + (6*100*25)/2) / (6*100*25)),
    27'((LuxNum + (7*100*25)/2) / (7*100*25)),
    27'((LuxNum + (8*100*25)/2) / (8*100*25)),
    27'((LuxNum + (1*100*428)/2) / (1*100*428)),
    27'((LuxNum + (2*100*428)/2) / (2*100*428)),
    27'((LuxNum + (3*100*428)/2) / (3*100*428)),
    27'((LuxNum + (4*100*428)/2) / (4*100*428)),
    27'((LuxNum + (5*100*428)/2) / (5*100*428)),
    27'((LuxNum + (6*100*428)/2) / (6*100*428)),
    27'((LuxNum + (7*100*428)/2) / (7*100*428)),
    27'((LuxNum + (8*100*428)/2) / (8*100*428)),
    27'((LuxNum + (1*100*9876)/2) / (1*100*9876)),
    27'((LuxNum + (2*100*9876)/2) / (2*100*9876)),
    27'((LuxNum + (3*100*9876)/2) / (3*100*9876)),
    27'((LuxNum + (4*100*9876)/2) / (4*100*9876)),
    27'((LuxNum + (5*100*9876)/2) / (5*100*9876)),
    27'((LuxNum + (6*100*9876)/2) / (6*100*9876)),
    27'((LuxNum + (7*100*9876)/2) / (7*100*9876)),
    27'((LuxNum + (8*100*9876)/2) / (8*100*9876))
  };

  typedef struct packed {
    logic take;
    logic load_t;
    logic mul_lo;
    logic mul_hi;
    logic commit;
  } lsal_cmd_t;

  typedef struct packed {
    logic need_lux;
  } lsal_sts_t;

endpackage

// ----- hw/rtl/lsal_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsal_ctrl
// Sequencer: accepts an item, steps the lux multiply passes, owns out valid.
// ----------------------------------------------------------------------------
module lsal_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  lsal_pkg::lsal_sts_t sts,
  output lsal_pkg::lsal_cmd_t cmd
);
  import lsal_pkg::*;

  localparam logic [2:0] ST_WAIT = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_MLO  = 3'd2;
  localparam logic [2:0] ST_MHI  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r == ST_WAIT) && (!out_valid_r || out_tready);
    case (state_r)
      ST_WAIT: begin
        cmd.take = in_tvalid && in_tready;
        if (cmd.take) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.load_t = 1'b1;
        if (sts.need_lux) begin
          state_nxt = ST_MLO;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = ST_WAIT;
        end
      end
      ST_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MHI;
      end
      ST_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_WAIT;
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // result slot is always free when a result is written
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_valid_r) else $error("commit into occupied output slot");

  a_take_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == ST_EVAL) else $error("accept did not start evaluation");

  a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_lo |=> cmd.mul_hi ##1 cmd.commit) else $error("multiply sequence broken");

endmodule

// ----- hw/rtl/lsal_dp.sv -----
// ----------------------------------------------------------------------------
// lsal_dp
// Sensor state, config registers, range stepping and the fixed-point lux path.
// ----------------------------------------------------------------------------
module lsal_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lsal_pkg::lsal_cmd_t               cmd,
  output lsal_pkg::lsal_sts_t               sts,
  input  logic                              cfg_we,
  input  logic [lsal_pkg::CFGI_W-1:0]       cfg_index,
  input  logic [lsal_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [lsal_pkg::CNT_W-1:0]        in_full_count,
  input  logic [lsal_pkg::CNT_W-1:0]        in_infrared_count,
  input  logic [lsal_pkg::RB_W-1:0]         in_control_readback,
  output logic [1:0]                        out_power_command,
  output logic                              out_control_write,
  output logic [5:0]                        out_control_value,
  output logic signed [lsal_pkg::LUX_W-1:0] out_published_lux,
  output logic                              out_lux_updated,
  output logic [1:0]                        out_phase
);
  import lsal_pkg::*;

  // configuration
  logic        active_r;
  logic [7:0]  idle_ticks_r;
  logic [15:0] bright_r;
  logic [16:0] dim_sum_r;

  // sensor state
  logic [1:0]              phase_r, phase_nxt;
  logic [7:0]              idle_r, idle_nxt;
  logic [1:0]              gain_r, gain_nxt;
  logic [2:0]              timing_r, timing_nxt;
  logic [CNT_W-1:0]        held_full_r, held_full_nxt;
  logic [CNT_W-1:0]        held_ir_r, held_ir_nxt;
  logic signed [LUX_W-1:0] pending_r, pending_nxt;
  logic signed [LUX_W-1:0] last_r, last_nxt;

  // latched item
  logic [CNT_W-1:0] lat_full_r, lat_ir_r;
  logic [RB_W-1:0]  lat_rb_r;

  // result flags
  logic [1:0] power_r, power_nxt;
  logic       cwrite_r, cwrite_nxt;
  logic       upd_r, upd_nxt;

  // lux path
  logic [26:0]             ir_k1;
  logic [25:0]             full_k2, ir_k2;
  logic signed [T_W-1:0]   t1, t2, tmax;
  logic [MAG_W-1:0]        mag_r;
  logic                    sign_r;
  logic [SCALE_W-1:0]      scale_r;
  logic [SLO_W-1:0]        mul_b;
  logic [PROD_W-1:0]       prod;
  logic [ACC_W-1:0]        acc_r;
  logic [LUX_W-1:0]        q;
  logic signed [LUX_W-1:0] lux;

  logic [CNT_W:0] sum;
  logic           mismatch, bright;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      idle_ticks_r <= 8'd2;
      bright_r     <= 16'd45000;
      dim_sum_r    <= 17'd30;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE:     active_r     <= cfg_wdata[0];
        CFG_IDLE_TICKS: idle_ticks_r <= cfg_wdata[7:0];
        CFG_BRIGHT:     bright_r     <= cfg_wdata[15:0];
        CFG_DIM_SUM:    dim_sum_r    <= cfg_wdata[16:0];
        default:        active_r     <= active_r;
      endcase
    end
  end

  assign sum      = {1'b0, held_full_r} + {1'b0, held_ir_r};
  assign mismatch = (lat_rb_r[7:4] != {2'b00, gain_r}) || (lat_rb_r[3:0] != {1'b0, timing_r});
  assign bright   = (held_full_r > bright_r) || (held_ir_r > bright_r);
  assign sts.need_lux = active_r && (phase_r == PH_CALC) && !mismatch && (sum != '0);

  // t1 = 1024*f - 1679*ir, t2 = 604*f - 881*ir
  assign ir_k1   = 27'(held_ir_r) * 27'd1679;
  assign full_k2 = 26'(held_full_r) * 26'd604;
  assign ir_k2   = 26'(held_ir_r) * 26'd881;
  assign t1      = signed'({2'b00, held_full_r, 10'b0}) - signed'({1'b0, ir_k1});
  assign t2      = signed'({2'b00, full_k2}) - signed'({2'b00, ir_k2});
  assign tmax    = (t1 > t2) ? t1 : t2;

  // shared 27x14 multiplier, two passes over the scale
  assign mul_b = cmd.mul_hi ? {1'b0, scale_r[SCALE_W-1:SLO_W]} : scale_r[SLO_W-1:0];
  assign prod  = PROD_W'(mag_r) * PROD_W'(mul_b);
  assign q     = acc_r[ACC_W-1:QSH];
  assign lux   = sign_r ? -signed'(q) : signed'(q);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lat_full_r <= in_full_count;
      lat_ir_r   <= in_infrared_count;
      lat_rb_r   <= in_control_readback;
    end
    if (cmd.load_t) begin
      sign_r  <= tmax[T_W-1];
      mag_r   <= tmax[T_W-1] ? MAG_W'(-tmax) : MAG_W'(tmax);
      scale_r <= SCALE_TAB[{gain_r, timing_r}];
    end
    if (cmd.mul_lo) begin
      acc_r <= ACC_W'(prod);
    end else if (cmd.mul_hi) begin
      acc_r <= acc_r + (ACC_W'(prod) << SLO_W);
    end
    if (cmd.commit) begin
      power_r  <= power_nxt;
      cwrite_r <= cwrite_nxt;
      upd_r    <= upd_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    idle_nxt      = idle_r;
    gain_nxt      = gain_r;
    timing_nxt    = timing_r;
    held_full_nxt = held_full_r;
    held_ir_nxt   = held_ir_r;
    pending_nxt   = pending_r;
    last_nxt      = last_r;
    power_nxt     = PWR_NONE;
    cwrite_nxt    = 1'b0;
    upd_nxt       = 1'b0;
    if (cmd.commit && active_r) begin
      case (phase_r)
        PH_IDLE: begin
          if (idle_r >= idle_ticks_r) begin
            power_nxt = PWR_SENSE;
            phase_nxt = PH_READ;
            idle_nxt  = '0;
          end else begin
            idle_nxt = idle_r + 8'd1;
          end
        end
        PH_READ: begin
          held_full_nxt = lat_full_r;
          held_ir_nxt   = lat_ir_r;
          power_nxt     = PWR_NOSENSE;
          phase_nxt     = PH_CALC;
        end
        PH_CALC: begin
          power_nxt = PWR_NOSENSE;
          if (mismatch) begin
            cwrite_nxt  = 1'b1;
            pending_nxt = LUX_INVALID;
          end else if (sum == '0) begin
            pending_nxt = LUX_INVALID;
          end else begin
            pending_nxt = lux;
            if (bright) begin
              if (gain_r == GAIN_HIGH) begin
                gain_nxt = GAIN_MED;
              end else if (gain_r == GAIN_MED) begin
                gain_nxt = GAIN_LOW;
              end else if (timing_r == TIM_LONG) begin
                timing_nxt = TIM_MID;
              end else if (timing_r == TIM_MID) begin
                timing_nxt = TIM_SHORT;
              end
            end else if (sum < dim_sum_r) begin
              if (timing_r == TIM_SHORT) begin
                timing_nxt = TIM_MID;
              end else if (timing_r == TIM_MID) begin
                timing_nxt = TIM_LONG;
              end else if (gain_r == GAIN_LOW) begin
                gain_nxt = GAIN_MED;
              end else if (gain_r == GAIN_MED) begin
                gain_nxt = GAIN_HIGH;
              end
            end
          end
          // range step: rewrite control and drop this sample
          if ((gain_nxt != gain_r) || (timing_nxt != timing_r)) begin
            cwrite_nxt = 1'b1;
            phase_nxt  = PH_IDLE;
          end else begin
            phase_nxt = PH_READY;
          end
        end
        PH_READY: begin
          upd_nxt   = (last_r != pending_r);
          last_nxt  = pending_r;
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      idle_r      <= 8'd2;
      gain_r      <= GAIN_MED;
      timing_r    <= TIM_MID;
      held_full_r <= '0;
      held_ir_r   <= '0;
      pending_r   <= '0;
      last_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      idle_r      <= idle_nxt;
      gain_r      <= gain_nxt;
      timing_r    <= timing_nxt;
      held_full_r <= held_full_nxt;
      held_ir_r   <= held_ir_nxt;
      pending_r   <= pending_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_power_command = power_r;
  assign out_control_write = cwrite_r;
  assign out_control_value = {gain_r, 1'b0, timing_r};
  assign out_published_lux = last_r;
  assign out_lux_updated   = upd_r;
  assign out_phase         = phase_r;

endmodule

// ----- hw/rtl/light_sensor_autorange_lux_core.sv -----
// ----------------------------------------------------------------------------
// light_sensor_autorange_lux_core
// Light sensor phase sequencer with autorange and fixed-point lux output.
//
//   channel   dir  handshake             payload
//   in_       in   in_tvalid/in_tready   full, infrared, control readback
//   out_      out  out_tvalid/out_tready one result per item
//   cfg_      in   cfg_we                cfg_index, cfg_wdata
//
// An item is accepted and then evaluated; a calc-phase item that needs lux
// also makes two passes of the shared 27x14 multiplier over the Q24 scale.
// The next item is taken only while the output register is empty or its
// result leaves at the same edge; a held result stalls the input.
// Reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module light_sensor_autorange_lux_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // full_count, infrared_count, control_readback
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // power_command, control_write, control_value,
                                  // published_lux, lux_updated, phase
  input  logic        cfg_we,
  input  logic [lsal_pkg::CFGI_W-1:0] cfg_index,
  input  logic [lsal_pkg::CFG_W-1:0]  cfg_wdata
);
  import lsal_pkg::*;

  lsal_cmd_t cmd;
  lsal_sts_t sts;

  logic [1:0]              power_command;
  logic                    control_write;
  logic [5:0]              control_value;
  logic signed [LUX_W-1:0] published_lux;
  logic                    lux_updated;
  logic [1:0]              phase;

  lsal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lsal_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_full_count       (in_tdata[15:0]),
    .in_infrared_count   (in_tdata[31:16]),
    .in_control_readback (in_tdata[39:32]),
    .out_power_command   (power_command),
    .out_control_write   (control_write),
    .out_control_value   (control_value),
    .out_published_lux   (published_lux),
    .out_lux_updated     (lux_updated),
    .out_phase           (phase)
  );

  assign out_tdata = {phase, lux_updated, published_lux, control_value,
                      control_write, power_command};

endmodule
